// ===== design/iso2unix_pkg.sv =====
// ----------------------------------------------------------------------------
// iso2unix_pkg
// Shared types and constants for the ISO date-time to Unix seconds block.
// ----------------------------------------------------------------------------
package iso2unix_pkg;

	// Field widths.
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 5;
	localparam int YEAR_W  = 14;
	localparam int FIELD_W = 7;
	localparam int SECS_W  = 38;

	// Pattern length and character codes.
	localparam logic [POS_W-1:0]  PATTERN_LEN = 5'd19;
	localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_DASH     = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_COLON    = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_T        = 8'h54;
	localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;

	// Calendar limits.
	localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1970;
	localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
	localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
	localparam logic [FIELD_W-1:0] MINUTE_MAX = 7'd59;
	localparam logic [FIELD_W-1:0] SECOND_MAX = 7'd60;

	// Divide by 100 through a reciprocal: exact for all 14-bit values.
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;

	// Civil-to-days constants.
	localparam int ERA_DAYS    = 146097;
	localparam int EPOCH_SHIFT = 719468;
	localparam int DAY_SECS    = 86400;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CHAR,
		ST_QYEAR,
		ST_QY,
		ST_YOE,
		ST_DOE,
		ST_DAYS,
		ST_MUL,
		ST_SUM
	} state_t;

	// Conversion steps that the datapath runs.
	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_QUOT_YEAR,
		STEP_QUOT_Y,
		STEP_YOE,
		STEP_DOE,
		STEP_DAYS,
		STEP_MUL
	} step_t;

	typedef struct packed {
		logic  take_char;
		step_t step;
		logic  load_res;
	} cmd_t;

	typedef struct packed {
		logic res_free;
	} status_t;

endpackage

// ===== design/iso_timestamp_to_unix_seconds.sv =====
// Timing: after the final character is accepted, the sequencer steps the datapath
// through the quotient, year-of-era, day-of-era, days and multiply steps, then loads
// the result register. No new string is taken until the result is loaded, since the
// conversion sequence shares one set of datapath registers.
// Input stalls during the conversion; a held result delays only the last step.
// Reset clears the parser state and the result flag; no result is pending.
// ----------------------------------------------------------------------------
// iso_timestamp_to_unix_seconds
// Parses YYYY-MM-DD(T or space)HH:MM:SS text and returns UTC Unix seconds.
// ----------------------------------------------------------------------------
module iso_timestamp_to_unix_seconds import iso2unix_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic               end_of_text,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               valid_res,
	output logic [SECS_W-1:0]  unix_seconds
);

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	iso2unix_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.end_of_text (end_of_text),
		.status      (status),
		.char_stall  (char_stall),
		.cmd         (cmd)
	);

	// Parser and conversion datapath.
	iso2unix_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.cmd          (cmd),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.valid_res    (valid_res),
		.unix_seconds (unix_seconds),
		.status       (status)
	);

endmodule

// ===== design/iso2unix_dpath.sv =====
// ----------------------------------------------------------------------------
// iso2unix_dpath
// Character parser, field accumulators, conversion registers and the
// result register.
// ----------------------------------------------------------------------------
module iso2unix_dpath import iso2unix_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CHAR_W-1:0]  char_code,
	input  cmd_t               cmd,
	input  logic               res_stall,
	output logic               res_valid,
	output logic               valid_res,
	output logic [SECS_W-1:0]  unix_seconds,
	output status_t            status
);

	// Parser state.
	logic [POS_W-1:0]   pos_q,    pos_n;
	logic [YEAR_W-1:0]  year_q,   year_n;
	logic [FIELD_W-1:0] month_q,  month_n;
	logic [FIELD_W-1:0] day_q,    day_n;
	logic [FIELD_W-1:0] hour_q,   hour_n;
	logic [FIELD_W-1:0] minute_q, minute_n;
	logic [FIELD_W-1:0] second_q, second_n;
	logic               fmt_bad_q, fmt_bad_n;

	// Conversion registers.
	logic [7:0]         q_yr_q;
	logic [YEAR_W-1:0]  y_q;
	logic [7:0]         q_y_q;
	logic               ok_q;
	logic [5:0]         era_q;
	logic [8:0]         yoe_q;
	logic [17:0]        doe_q;
	logic [21:0]        days_q;
	logic [SECS_W-1:0]  prod_q;
	logic [18:0]        tod_q;

	// Result register.
	logic               res_valid_q;
	logic               valid_res_q;
	logic [SECS_W-1:0]  secs_q;

	logic               is_digit;
	logic [3:0]         digit;
	logic [26:0]        qprod_yr;
	logic [26:0]        qprod_y;
	logic [YEAR_W-1:0]  rem100;
	logic               leap;
	logic               ok_n;
	logic [18:0]        doe_sum;
	logic [23:0]        days_sum;
	logic [38:0]        prod_full;
	logic [18:0]        tod_sum;

	function automatic logic [FIELD_W-1:0] acc2(input logic [FIELD_W-1:0] f,
			input logic [3:0] d);
		logic [10:0] t;
		t = {4'd0, f} * 11'd10 + {7'd0, d};
		return t[FIELD_W-1:0];
	endfunction

	function automatic logic [YEAR_W-1:0] acc4(input logic [YEAR_W-1:0] f,
			input logic [3:0] d);
		logic [17:0] t;
		t = {4'd0, f} * 18'd10 + {14'd0, d};
		return t[YEAR_W-1:0];
	endfunction

	// Month length, with February set by the leap flag.
	function automatic logic [4:0] month_len(input logic [FIELD_W-1:0] m,
			input logic lp);
		logic [4:0] r;
		case (m)
			7'd2:                      r = lp ? 5'd29 : 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
			7'd1, 7'd3, 7'd5, 7'd7,
			7'd8, 7'd10, 7'd12:        r = 5'd31;
			default:                   r = 5'd0;
		endcase
		return r;
	endfunction

	// Days before the first of the month in a March-based year.
	function automatic logic [8:0] month_offset(input logic [FIELD_W-1:0] m);
		logic [8:0] r;
		case (m)
			7'd3:    r = 9'd0;
			7'd4:    r = 9'd31;
			7'd5:    r = 9'd61;
			7'd6:    r = 9'd92;
			7'd7:    r = 9'd122;
			7'd8:    r = 9'd153;
			7'd9:    r = 9'd184;
			7'd10:   r = 9'd214;
			7'd11:   r = 9'd245;
			7'd12:   r = 9'd275;
			7'd1:    r = 9'd306;
			7'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Character decode and field accumulation.
	always_comb begin
		is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		digit     = 4'(char_code - CH_ZERO);
		pos_n     = pos_q;
		year_n    = year_q;
		month_n   = month_q;
		day_n     = day_q;
		hour_n    = hour_q;
		minute_n  = minute_q;
		second_n  = second_q;
		fmt_bad_n = fmt_bad_q;
		if (cmd.take_char && (pos_q < PATTERN_LEN)) begin
			pos_n = pos_q + 5'd1;
			case (pos_q)
				5'd0, 5'd1, 5'd2, 5'd3: begin
					if (is_digit) year_n = acc4(year_q, digit);
					else fmt_bad_n = 1'b1;
				end
				5'd5, 5'd6: begin
					if (is_digit) month_n = acc2(month_q, digit);
					else fmt_bad_n = 1'b1;
				end
				5'd8, 5'd9: begin
					if (is_digit) day_n = acc2(day_q, digit);
					else fmt_bad_n = 1'b1;
				end
				5'd11, 5'd12: begin
					if (is_digit) hour_n = acc2(hour_q, digit);
					else fmt_bad_n = 1'b1;
				end
				5'd14, 5'd15: begin
					if (is_digit) minute_n = acc2(minute_q, digit);
					else fmt_bad_n = 1'b1;
				end
				5'd17, 5'd18: begin
					if (is_digit) second_n = acc2(second_q, digit);
					else fmt_bad_n = 1'b1;
				end
				5'd4, 5'd7: begin
					if (char_code != CH_DASH) fmt_bad_n = 1'b1;
				end
				5'd10: begin
					if ((char_code != CH_T) && (char_code != CH_SPACE)) fmt_bad_n = 1'b1;
				end
				5'd13, 5'd16: begin
					if (char_code != CH_COLON) fmt_bad_n = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (cmd.load_res) begin
			pos_n     = '0;
			year_n    = '0;
			month_n   = '0;
			day_n     = '0;
			hour_n    = '0;
			minute_n  = '0;
			second_n  = '0;
			fmt_bad_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= '0;
			hour_q    <= '0;
			minute_q  <= '0;
			second_q  <= '0;
			fmt_bad_q <= 1'b0;
		end else begin
			pos_q     <= pos_n;
			year_q    <= year_n;
			month_q   <= month_n;
			day_q     <= day_n;
			hour_q    <= hour_n;
			minute_q  <= minute_n;
			second_q  <= second_n;
			fmt_bad_q <= fmt_bad_n;
		end
	end

	// Arithmetic for each conversion step.
	always_comb begin
		qprod_yr  = {13'd0, year_q} * 27'(DIV100_MUL);
		qprod_y   = {13'd0, y_q} * 27'(DIV100_MUL);
		rem100    = year_q - 14'({6'd0, q_yr_q} * 14'd100);
		leap      = (year_q[1:0] == 2'd0) && ((rem100 != '0) || (q_yr_q[1:0] == 2'd0));
		ok_n      = (pos_q == PATTERN_LEN) && !fmt_bad_q &&
		            (year_q >= YEAR_MIN) &&
		            (month_q >= 7'd1) && (month_q <= MONTH_MAX) &&
		            (day_q >= 7'd1) && (day_q <= {2'd0, month_len(month_q, leap)}) &&
		            (hour_q <= HOUR_MAX) && (minute_q <= MINUTE_MAX) &&
		            (second_q <= SECOND_MAX);
		doe_sum   = {10'd0, yoe_q} * 19'd365 + 19'(yoe_q >> 2) +
		            19'(month_offset(month_q)) + 19'(day_q) - 19'd1 -
		            19'(q_y_q[1:0]);
		days_sum  = {18'd0, era_q} * 24'(ERA_DAYS) + {6'd0, doe_q} - 24'(EPOCH_SHIFT);
		prod_full = {17'd0, days_q} * 39'(DAY_SECS);
		tod_sum   = {12'd0, hour_q} * 19'd3600 + {12'd0, minute_q} * 19'd60 +
		            {12'd0, second_q};
	end

	// Conversion registers, one step per cycle.
	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_QUOT_YEAR: begin
				q_yr_q <= 8'(qprod_yr >> DIV100_SHIFT);
				y_q    <= year_q - ((month_q <= 7'd2) ? 14'd1 : 14'd0);
			end
			STEP_QUOT_Y: begin
				q_y_q <= 8'(qprod_y >> DIV100_SHIFT);
				ok_q  <= ok_n;
			end
			STEP_YOE: begin
				era_q <= q_y_q[7:2];
				yoe_q <= 9'(y_q - 14'({8'd0, q_y_q[7:2]} * 14'd400));
			end
			STEP_DOE: begin
				doe_q <= doe_sum[17:0];
			end
			STEP_DAYS: begin
				days_q <= days_sum[21:0];
			end
			STEP_MUL: begin
				prod_q <= prod_full[SECS_W-1:0];
				tod_q  <= tod_sum;
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			valid_res_q <= ok_q;
			secs_q      <= ok_q ? (prod_q + {19'd0, tod_q}) : '0;
		end
	end

	assign res_valid       = res_valid_q;
	assign valid_res       = valid_res_q;
	assign unix_seconds    = secs_q;
	assign status.res_free = !res_valid_q || !res_stall;

	// A failed check always carries zero seconds.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !valid_res) |-> (unix_seconds == '0))
		else $error("invalid result with nonzero seconds");

	// The position count saturates at the pattern length.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PATTERN_LEN)
		else $error("character position beyond pattern");

	// A new result never overwrites one that is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_res && res_valid_q && res_stall))
		else $error("result overwritten while stalled");

	// State is clear after a result is loaded.
	a_clear_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |=> ((pos_q == '0) && !fmt_bad_q))
		else $error("parser state not cleared after result");

endmodule

// ===== design/iso2unix_ctrl.sv =====
// ----------------------------------------------------------------------------
// iso2unix_ctrl
// Sequencer: accepts characters, then steps the datapath through the
// conversion and loads the result.
// ----------------------------------------------------------------------------
module iso2unix_ctrl import iso2unix_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    char_valid,
	input  logic    end_of_text,
	input  status_t status,
	output logic    char_stall,
	output cmd_t    cmd
);

	state_t state_q, state_n;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CHAR;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands.
	always_comb begin
		state_n       = state_q;
		cmd.take_char = 1'b0;
		cmd.step      = STEP_NONE;
		cmd.load_res  = 1'b0;
		char_stall    = 1'b1;
		case (state_q)
			ST_CHAR: begin
				char_stall    = 1'b0;
				cmd.take_char = char_valid;
				if (char_valid && end_of_text) state_n = ST_QYEAR;
			end
			ST_QYEAR: begin
				cmd.step = STEP_QUOT_YEAR;
				state_n  = ST_QY;
			end
			ST_QY: begin
				cmd.step = STEP_QUOT_Y;
				state_n  = ST_YOE;
			end
			ST_YOE: begin
				cmd.step = STEP_YOE;
				state_n  = ST_DOE;
			end
			ST_DOE: begin
				cmd.step = STEP_DOE;
				state_n  = ST_DAYS;
			end
			ST_DAYS: begin
				cmd.step = STEP_DAYS;
				state_n  = ST_MUL;
			end
			ST_MUL: begin
				cmd.step = STEP_MUL;
				state_n  = ST_SUM;
			end
			ST_SUM: begin
				if (status.res_free) begin
					cmd.load_res = 1'b1;
					state_n      = ST_CHAR;
				end
			end
			default: begin
				state_n = ST_CHAR;
			end
		endcase
	end

	// The final character starts the conversion sequence.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && end_of_text) |=> (state_q == ST_QYEAR))
		else $error("conversion did not start after final character");

	// A blocked result holds the sequencer in place.
	a_hold_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && !status.res_free) |=> (state_q == ST_SUM))
		else $error("sequencer left while result was blocked");

	// Characters are taken again right after a result is loaded.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |=> !char_stall)
		else $error("input not reopened after result");

endmodule

// ===== tb/iso_stamp_checker.sv =====
// ----------------------------------------------------------------------------
// iso_stamp_checker
// Watches both channels of the ISO date-time converter. It follows the parse
// of each accepted character, works out the expected result when a string
// ends, and compares every result transaction against the oldest expectation.
// ----------------------------------------------------------------------------
module iso_stamp_checker import iso2unix_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	input  logic               char_stall,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic               end_of_text,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic               valid_res,
	input  logic [SECS_W-1:0]  unix_seconds,
	output int                 mismatch_count,
	output int                 stamps_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              ok;
		logic [SECS_W-1:0] secs;
	} stamp_t;

	// Expected results, oldest first.
	stamp_t pending_stamps[$];

	// Parser state as the block should hold it.
	logic [POS_W-1:0]   pos_cnt     = '0;
	logic [YEAR_W-1:0]  year_acc    = '0;
	logic [FIELD_W-1:0] month_acc   = '0;
	logic [FIELD_W-1:0] day_acc     = '0;
	logic [FIELD_W-1:0] hour_acc    = '0;
	logic [FIELD_W-1:0] minute_acc  = '0;
	logic [FIELD_W-1:0] second_acc  = '0;
	logic               pattern_err = 1'b0;

	int err_total     = 0;
	int pending_total = 0;

	assign mismatch_count = err_total;
	assign stamps_pending = pending_total;

	// Checks the pattern length and format and the calendar ranges, then converts a
	// civil date and time to Unix seconds with the era and day-of-era method.
	function automatic stamp_t predict_stamp(input logic [POS_W-1:0] npos, input logic bad,
			input logic [YEAR_W-1:0] yr, input logic [FIELD_W-1:0] mo,
			input logic [FIELD_W-1:0] dy, input logic [FIELD_W-1:0] hr,
			input logic [FIELD_W-1:0] mi, input logic [FIELD_W-1:0] se);
		stamp_t            r;
		bit                leap;
		int unsigned       mdays;
		longint unsigned   y, era, yoe, mp, doy, doe, days;
		r.ok = 1'b0;
		r.secs = '0;
		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		case (mo)
			2: begin
				mdays = leap ? 29 : 28;
			end
			4, 6, 9, 11: begin
				mdays = 30;
			end
			default: begin
				mdays = 31;
			end
		endcase
		if (npos < PATTERN_LEN || bad || yr < YEAR_MIN || mo < 1 || mo > MONTH_MAX ||
				dy < 1 || dy > mdays || hr > HOUR_MAX || mi > MINUTE_MAX ||
				se > SECOND_MAX)
			return r;
		y = yr - ((mo <= 2) ? 1 : 0);
		era = y / 400;
		yoe = y - era * 400;
		mp = (mo > 2) ? mo - 3 : mo + 9;
		doy = (153 * mp + 2) / 5 + dy - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		days = era * ERA_DAYS + doe - EPOCH_SHIFT;
		r.ok = 1'b1;
		r.secs = SECS_W'(days * DAY_SECS + hr * 3600 + mi * 60 + se);
		return r;
	endfunction

	// Follow the parse on each input transaction, then check each result.
	always @(posedge clk or negedge arst_n) begin : track
		logic       is_digit;
		logic [3:0] digit;
		stamp_t     due;
		if (!arst_n) begin
			pos_cnt = '0;
			year_acc = '0;
			month_acc = '0;
			day_acc = '0;
			hour_acc = '0;
			minute_acc = '0;
			second_acc = '0;
			pattern_err = 1'b0;
			pending_stamps.delete();
			pending_total <= 0;
		end else begin
			if (char_valid && !char_stall) begin
				is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
				digit = 4'(char_code - CH_ZERO);
				// Only the first PATTERN_LEN characters of a string are checked and used.
				if (pos_cnt < PATTERN_LEN) begin
					case (pos_cnt)
						4, 7: begin
							if (char_code != CH_DASH) pattern_err = 1'b1;
						end
						10: begin
							if (char_code != CH_T && char_code != CH_SPACE)
								pattern_err = 1'b1;
						end
						13, 16: begin
							if (char_code != CH_COLON) pattern_err = 1'b1;
						end
						default: begin
							if (!is_digit) begin
								pattern_err = 1'b1;
							end else begin
								case (pos_cnt)
									0, 1, 2, 3: year_acc = YEAR_W'(year_acc * 10 + digit);
									5, 6: month_acc = FIELD_W'(month_acc * 10 + digit);
									8, 9: day_acc = FIELD_W'(day_acc * 10 + digit);
									11, 12: hour_acc = FIELD_W'(hour_acc * 10 + digit);
									14, 15: minute_acc = FIELD_W'(minute_acc * 10 + digit);
									default: second_acc = FIELD_W'(second_acc * 10 + digit);
								endcase
							end
						end
					endcase
					pos_cnt = POS_W'(pos_cnt + 1);
				end
				// The marked character closes the string and starts a new one.
				if (end_of_text) begin
					pending_stamps.push_back(predict_stamp(pos_cnt, pattern_err, year_acc,
						month_acc, day_acc, hour_acc, minute_acc, second_acc));
					pos_cnt = '0;
					year_acc = '0;
					month_acc = '0;
					day_acc = '0;
					hour_acc = '0;
					minute_acc = '0;
					second_acc = '0;
					pattern_err = 1'b0;
				end
			end
			if (res_valid && !res_stall) begin
				if (pending_stamps.size() == 0) begin
					$error("result with none expected: valid_res %0b unix_seconds %0d",
						valid_res, unix_seconds);
					err_total++;
				end else begin
					due = pending_stamps.pop_front();
					if (valid_res !== due.ok) begin
						$error("valid_res: expected %0b, actual %0b", due.ok, valid_res);
						err_total++;
					end
					if (unix_seconds !== due.secs) begin
						$error("unix_seconds: expected %0d, actual %0d", due.secs,
							unix_seconds);
						err_total++;
					end
				end
			end
			pending_total <= pending_stamps.size();
		end
	end

endmodule

// ===== tb/iso_timestamp_to_unix_seconds_test.sv =====
// ----------------------------------------------------------------------------
// iso_timestamp_to_unix_seconds_test
// Feeds timestamp strings one character per transaction into the converter:
// directed strings for the calendar edges and format errors first, then
// random strings, mostly well formed, with broken and noisy ones mixed in.
// Random idling and stalling run in phases; a separate checker compares.
// ----------------------------------------------------------------------------
module iso_timestamp_to_unix_seconds_test;
	import iso2unix_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_CHARS = 1200;

	logic              clk;
	logic              arst_n;
	logic              char_valid;
	logic              char_stall;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_text;
	logic              res_valid;
	logic              res_stall;
	logic              valid_res;
	logic [SECS_W-1:0] unix_seconds;
	int                mismatches;
	int                stamps_pending;

	int                idle_pct    = 0;
	int                stall_pct   = 0;
	int                chars_sent  = 0;
	int                cycle_count = 0;
	byte unsigned      text_bytes[$];

	// Edges of the calendar and every kind of format error.
	string directed_texts[23] = '{
		"1970-01-01T00:00:00",
		"2000-02-29 23:59:60",
		"9999-12-31T23:59:60",
		"1969-12-31T23:59:59",
		"0000-01-01T00:00:00",
		"2100-02-29T12:00:00",
		"2024-02-29T12:00:00",
		"2023-02-29T12:00:00",
		"2023-00-10T00:00:00",
		"2023-13-10T00:00:00",
		"2023-05-00T00:00:00",
		"2023-04-31T00:00:00",
		"2023-01-32T00:00:00",
		"2023-06-15T24:00:00",
		"2023-06-15T23:60:00",
		"2023-06-15T23:59:61",
		"2023/06-15T10:20:30",
		"2023-06-15X10:20:30",
		"2023-06-15T10.20:30",
		"20/3-06-15T10:20:3:",
		"2023-06-15T10:20",
		"7",
		"2038-01-19T03:14:07Z+extra"
	};

	iso_timestamp_to_unix_seconds dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.valid_res    (valid_res),
		.unix_seconds (unix_seconds)
	);

	iso_stamp_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.char_code      (char_code),
		.end_of_text    (end_of_text),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.valid_res      (valid_res),
		.unix_seconds   (unix_seconds),
		.mismatch_count (mismatches),
		.stamps_pending (stamps_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// The result side stalls at random at the rate of the current phase.
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Append a zero-padded decimal number to the text.
	function automatic void put_number(input int value, input int digits);
		for (int i = digits - 1; i >= 0; i--)
			text_bytes.push_back(8'(CH_ZERO + (value / (10 ** i)) % 10));
	endfunction

	// Send the text as one character per transaction, the last one marked.
	// Called and left at a falling edge.
	task automatic send_text();
		for (int i = 0; i < text_bytes.size(); i++) begin
			while ($urandom_range(99) < idle_pct) begin
				char_valid <= 1'b0;
				@(negedge clk);
			end
			char_valid <= 1'b1;
			char_code <= text_bytes[i];
			end_of_text <= (i == text_bytes.size() - 1);
			do @(posedge clk); while (char_stall);
			@(negedge clk);
		end
		chars_sent += text_bytes.size();
	endtask

	initial begin
		int           yr, mo, dy, hr, mi, se, kind, cut;
		byte unsigned sep;
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_code = '0;
		end_of_text = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed strings with no idling.
		foreach (directed_texts[n]) begin
			text_bytes.delete();
			for (int i = 0; i < directed_texts[n].len(); i++)
				text_bytes.push_back(directed_texts[n][i]);
			send_text();
		end

		// Random strings in four idling and stalling phases.
		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS) begin
			case (chars_sent / (RANDOM_CHARS / 4))
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct = 20;
					stall_pct = 20;
				end
			endcase
			text_bytes.delete();
			kind = $urandom_range(99);
			if (kind < 90) begin
				// A timestamp shaped string, mostly within the calendar ranges.
				yr = ($urandom_range(9) == 0) ? $urandom_range(9999) : $urandom_range(9999, 1970);
				mo = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
				dy = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(31, 1);
				hr = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(23);
				mi = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(59);
				se = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(60);
				sep = $urandom_range(1) ? CH_T : CH_SPACE;
				put_number(yr, 4);
				text_bytes.push_back(CH_DASH);
				put_number(mo, 2);
				text_bytes.push_back(CH_DASH);
				put_number(dy, 2);
				text_bytes.push_back(sep);
				put_number(hr, 2);
				text_bytes.push_back(CH_COLON);
				put_number(mi, 2);
				text_bytes.push_back(CH_COLON);
				put_number(se, 2);
				if (kind < 15) begin
					// One character of the pattern replaced by a random byte.
					text_bytes[$urandom_range(18)] = 8'($urandom_range(255));
				end else if (kind < 25) begin
					// Cut short before the pattern is complete.
					cut = $urandom_range(18, 1);
					while (text_bytes.size() > cut)
						void'(text_bytes.pop_back());
				end else if ($urandom_range(3) == 0) begin
					// Trailing characters past the pattern.
					repeat ($urandom_range(6, 1))
						text_bytes.push_back(8'($urandom_range(255)));
				end
			end else begin
				// Noise of random length.
				repeat ($urandom_range(30, 1))
					text_bytes.push_back(8'($urandom_range(255)));
			end
			send_text();
		end
		char_valid <= 1'b0;

		// Drain the outstanding results, then allow for the conversion latency.
		while (stamps_pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && stamps_pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
